/* rtl/stepper_half_step_sequencer_assert.svh */
// Assertion macros shared by the stepper half-step sequencer RTL.
`ifndef STEPPER_HALF_STEP_SEQUENCER_ASSERT_SVH
`define STEPPER_HALF_STEP_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge outside reset.
`define SHS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("stepper sequencer assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define SHS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("stepper sequencer assertion failed");

`else

`define SHS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SHS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/shs_pkg.sv */
// Package with types, codes and the half-step phase table of the sequencer.
`timescale 1ns / 1ps

package shs_pkg;

	// Configuration register indexes.
	localparam logic [1:0] REG_ENABLE    = 2'd0;
	localparam logic [1:0] REG_DIRECTION = 2'd1;
	localparam logic [1:0] REG_PERIOD    = 2'd2;

	// Direction codes.
	localparam logic [1:0] DIR_STOP  = 2'd0;
	localparam logic [1:0] DIR_BRAKE = 2'd1;
	localparam logic [1:0] DIR_CW    = 2'd2;
	localparam logic [1:0] DIR_CCW   = 2'd3;

	// Bridge mode codes.
	localparam logic [1:0] MODE_BRAKE = 2'd0;
	localparam logic [1:0] MODE_FWD   = 2'd1;
	localparam logic [1:0] MODE_REV   = 2'd2;

	localparam int CFG_DATA_BITS = 16;
	localparam int COUNT_FIELD_BITS = 32;
	localparam int OUT_DATA_BITS = 40;

	// One result item.
	typedef struct packed {
		logic        drive_valid;
		logic [1:0]  bridge_a_mode;
		logic [1:0]  bridge_b_mode;
		logic [31:0] steps_remaining;
		logic        move_done;
	} result_t;

	// Bridge modes of one half-step phase, returned as {coil B, coil A}.
	function automatic logic [3:0] phase_modes(input logic [2:0] phase);
		logic [3:0] modes;
		case (phase)
			3'd0:    modes = {MODE_BRAKE, MODE_FWD};
			3'd1:    modes = {MODE_FWD, MODE_FWD};
			3'd2:    modes = {MODE_FWD, MODE_BRAKE};
			3'd3:    modes = {MODE_FWD, MODE_REV};
			3'd4:    modes = {MODE_BRAKE, MODE_REV};
			3'd5:    modes = {MODE_REV, MODE_REV};
			3'd6:    modes = {MODE_REV, MODE_BRAKE};
			3'd7:    modes = {MODE_REV, MODE_FWD};
			default: modes = {MODE_BRAKE, MODE_BRAKE};
		endcase
		return modes;
	endfunction

endpackage

/* rtl/shs_core.sv */
// Sequencer state: configuration, period counter, phase and step count.
`timescale 1ns / 1ps

`include "stepper_half_step_sequencer_assert.svh"

module shs_core #(
	parameter int COUNT_BITS  = 32,
	parameter int PERIOD_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wen,
	input  logic [1:0]                           cfg_index,
	input  logic [shs_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
	input  logic                                 item_fire,
	input  logic                                 item_cmd,
	input  logic [shs_pkg::COUNT_FIELD_BITS-1:0] item_count,
	output shs_pkg::result_t                     res
);

	logic                   enable_q;
	logic [1:0]             direction_q;
	logic [PERIOD_BITS-1:0] period_q;
	logic [PERIOD_BITS-1:0] counter_q;
	logic [2:0]             phase_q;
	logic [1:0]             last_dir_q;
	logic [COUNT_BITS-1:0]  remaining_q;

	logic                   is_tick;
	logic                   step_event;
	logic                   step_active;
	logic                   has_steps;
	logic                   do_step;
	logic [3:0]             modes;
	logic [2:0]             phase_next;
	logic [COUNT_BITS-1:0]  remaining_next;

	// Step event and step decision for the item now leaving the input register.
	always_comb begin
		is_tick     = !item_cmd;
		step_event  = is_tick && (counter_q >= period_q);
		step_active = step_event && enable_q &&
			(direction_q == shs_pkg::DIR_CW || direction_q == shs_pkg::DIR_CCW);
		has_steps   = (remaining_q != '0);
		do_step     = step_active && has_steps;
		modes       = shs_pkg::phase_modes(phase_q);
	end

	// Next phase: advance with the direction, or restart at zero on a reversal.
	always_comb begin
		if (direction_q == shs_pkg::DIR_CW) begin
			phase_next = (last_dir_q == shs_pkg::DIR_CCW) ? 3'd0 : phase_q + 3'd1;
		end else begin
			phase_next = (last_dir_q == shs_pkg::DIR_CW) ? 3'd0 : phase_q - 3'd1;
		end
	end

	// Remaining count after this item.
	always_comb begin
		if (item_cmd) begin
			remaining_next = item_count[COUNT_BITS-1:0];
		end else if (do_step) begin
			remaining_next = remaining_q - COUNT_BITS'(1);
		end else begin
			remaining_next = remaining_q;
		end
	end

	// Result of this item.
	always_comb begin
		res.drive_valid     = step_active;
		res.bridge_a_mode   = do_step ? modes[1:0] : shs_pkg::MODE_BRAKE;
		res.bridge_b_mode   = do_step ? modes[3:2] : shs_pkg::MODE_BRAKE;
		res.steps_remaining = shs_pkg::COUNT_FIELD_BITS'(remaining_next);
		res.move_done       = step_active && !has_steps;
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= 1'b0;
			direction_q <= shs_pkg::DIR_STOP;
			period_q    <= PERIOD_BITS'(1000);
		end else if (cfg_wen) begin
			case (cfg_index)
				shs_pkg::REG_ENABLE:    enable_q    <= cfg_wdata[0];
				shs_pkg::REG_DIRECTION: direction_q <= cfg_wdata[1:0];
				shs_pkg::REG_PERIOD:    period_q    <= PERIOD_BITS'(cfg_wdata);
				default: ;
			endcase
		end
	end

	// Sequencer state, updated once per transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q   <= '0;
			phase_q     <= 3'd0;
			last_dir_q  <= shs_pkg::DIR_STOP;
			remaining_q <= '0;
		end else if (item_fire) begin
			if (is_tick) begin
				counter_q <= step_event ? '0 : counter_q + PERIOD_BITS'(1);
			end
			if (do_step) begin
				phase_q    <= phase_next;
				last_dir_q <= direction_q;
			end
			remaining_q <= remaining_next;
		end
	end

	`SHS_ASSERT_NEXT(a_phase_holds_when_idle, clk, arst_n, !item_fire, $stable(phase_q))
	`SHS_ASSERT_IMPL(a_done_brakes, clk, arst_n, item_fire && res.move_done,
		res.drive_valid && res.bridge_a_mode == shs_pkg::MODE_BRAKE &&
		res.bridge_b_mode == shs_pkg::MODE_BRAKE)
	`SHS_ASSERT_NEXT(a_step_decrements, clk, arst_n, item_fire && do_step,
		remaining_q == $past(remaining_q) - COUNT_BITS'(1))

endmodule

/* rtl/stepper_half_step_sequencer.sv */
// Top level of the bipolar stepper half-step sequencer with stream ports.
//
// The sequencer takes one item per clock cycle unless a waiting result holds
// it off: a tick or a load of the step count. Each accepted transfer produces
// exactly one result. The result leaves through an input register and a result
// register. The rate is set by the update of the period counter, phase and step
// count in the core, which sees each item in the cycle it leaves the input
// register. A waiting result stops input only once the input register holds an
// item as well. Both registers advance whenever the result register is empty
// or being drained, so the block holds at most two items. The step_period
// register defaults to 1000, so a step event falls on every 1001st tick.
`timescale 1ns / 1ps

module stepper_half_step_sequencer #(
	parameter int COUNT_BITS  = 32,
	parameter int PERIOD_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Configuration write port.
	input  logic                                 cfg_wen,
	input  logic [1:0]                           cfg_index,
	input  logic [shs_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
	// Input stream.
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [shs_pkg::COUNT_FIELD_BITS-1:0] s_axis_tdata,  // [31:0] step_count
	input  logic                                 s_axis_tuser,  // [0] command
	// Result stream.
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// [0] drive_valid, [2:1] bridge_a_mode, [4:3] bridge_b_mode,
	// [36:5] steps_remaining, [37] move_done, [39:38] zero
	output logic [shs_pkg::OUT_DATA_BITS-1:0]    m_axis_tdata
);

	logic                                 valid_s1;
	logic                                 cmd_s1;
	logic [shs_pkg::COUNT_FIELD_BITS-1:0] count_s1;
	logic                                 out_valid_q;
	shs_pkg::result_t                     res_q;
	shs_pkg::result_t                     res;
	logic                                 out_free;
	logic                                 adv_s1;

	// Handshake: the result register takes a new item when empty or draining.
	assign out_free      = !out_valid_q || m_axis_tready;
	assign adv_s1        = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			cmd_s1   <= s_axis_tuser;
			count_s1 <= s_axis_tdata;
		end
	end

	shs_core #(
		.COUNT_BITS  (COUNT_BITS),
		.PERIOD_BITS (PERIOD_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.item_fire  (adv_s1),
		.item_cmd   (cmd_s1),
		.item_count (count_s1),
		.res        (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_q <= res;
		end
	end

	// Pack the result fields, lowest field first.
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, res_q.move_done, res_q.steps_remaining,
		res_q.bridge_b_mode, res_q.bridge_a_mode, res_q.drive_valid};

endmodule

/* tb/tb_stepper_half_step_sequencer.sv */
// Self-checking testbench for the stepper half-step sequencer, with directed and random moves.
`timescale 1ns / 1ps

module tb_stepper_half_step_sequencer;

	localparam int HOLD_CYCLES  = 200;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS  = 66;
	localparam int DEFAULT_TICKS = 40;

	// Command codes carried in tuser.
	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_LOAD = 1'b1;

	// Half-step phase table, two bits per phase, phase 0 in the lowest bits.
	localparam logic [15:0] COIL_A_TABLE = {shs_pkg::MODE_FWD, shs_pkg::MODE_BRAKE,
		shs_pkg::MODE_REV, shs_pkg::MODE_REV, shs_pkg::MODE_REV, shs_pkg::MODE_BRAKE,
		shs_pkg::MODE_FWD, shs_pkg::MODE_FWD};
	localparam logic [15:0] COIL_B_TABLE = {shs_pkg::MODE_REV, shs_pkg::MODE_REV,
		shs_pkg::MODE_REV, shs_pkg::MODE_BRAKE, shs_pkg::MODE_FWD, shs_pkg::MODE_FWD,
		shs_pkg::MODE_FWD, shs_pkg::MODE_BRAKE};

	logic                                 clk;
	logic                                 arst_n;
	logic                                 cfg_wen;
	logic [1:0]                           cfg_index;
	logic [shs_pkg::CFG_DATA_BITS-1:0]    cfg_wdata;
	logic                                 s_axis_tvalid;
	logic                                 s_axis_tready;
	logic [shs_pkg::COUNT_FIELD_BITS-1:0] s_axis_tdata;  // [31:0] step_count
	logic                                 s_axis_tuser;  // [0] command
	logic                                 m_axis_tvalid;
	logic                                 m_axis_tready;
	// [0] drive_valid, [2:1] bridge_a_mode, [4:3] bridge_b_mode,
	// [36:5] steps_remaining, [37] move_done, [39:38] zero
	logic [shs_pkg::OUT_DATA_BITS-1:0]    m_axis_tdata;

	// Predictor state and its copy of the registers.
	logic        model_enable    = 1'b0;
	logic [1:0]  model_dir       = shs_pkg::DIR_STOP;
	logic [15:0] model_period    = 16'd1000;
	logic [15:0] model_ticks     = '0;
	logic [2:0]  model_phase     = '0;
	logic [1:0]  model_last_dir  = shs_pkg::DIR_STOP;
	logic [31:0] model_steps     = '0;

	shs_pkg::result_t expected_drive[$];
	int      mismatch_count = 0;
	int      cycle_count = 0;
	bit      sender_gaps_on = 1'b1;
	bit      receiver_stalls_on = 1'b1;
	bit      hold_request = 1'b0;

	stepper_half_step_sequencer DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Works out the result of one item and advances the predicted state.
	function automatic shs_pkg::result_t predict_sequencer(input logic cmd,
			input logic [31:0] count);
		shs_pkg::result_t drive;
		logic    step_event;
		drive = '0;
		step_event = 1'b0;
		if (cmd == CMD_LOAD) begin
			model_steps = count;
		end else if (model_ticks >= model_period) begin
			model_ticks = '0;
			step_event = 1'b1;
		end else begin
			model_ticks = model_ticks + 16'd1;
		end
		if (step_event && model_enable &&
				(model_dir == shs_pkg::DIR_CW || model_dir == shs_pkg::DIR_CCW)) begin
			drive.drive_valid = 1'b1;
			if (model_steps != '0) begin
				drive.bridge_a_mode = COIL_A_TABLE[{model_phase, 1'b0} +: 2];
				drive.bridge_b_mode = COIL_B_TABLE[{model_phase, 1'b0} +: 2];
				// A reversal drives the current phase and then restarts from phase zero.
				if (model_dir == shs_pkg::DIR_CW)
					model_phase = (model_last_dir == shs_pkg::DIR_CCW) ? 3'd0
						: model_phase + 3'd1;
				else
					model_phase = (model_last_dir == shs_pkg::DIR_CW) ? 3'd0
						: model_phase - 3'd1;
				model_last_dir = model_dir;
				model_steps = model_steps - 32'd1;
			end else begin
				drive.move_done = 1'b1;
			end
		end
		drive.steps_remaining = model_steps;
		return drive;
	endfunction

	task automatic report_field(input string field, input logic [31:0] want,
			input logic [31:0] seen);
		if (seen !== want) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, seen);
			mismatch_count++;
		end
	endtask

	// Checks each result transfer and predicts each accepted input transfer.
	always @(posedge clk) begin : result_monitor
		shs_pkg::result_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_drive.size() == 0) begin
					$display("%0t: result with nothing expected: expected none, actual %h",
						$time, m_axis_tdata);
					mismatch_count++;
				end else begin
					want = expected_drive.pop_front();
					report_field("drive_valid", 32'(want.drive_valid),
						32'(m_axis_tdata[0]));
					report_field("bridge_a_mode", 32'(want.bridge_a_mode),
						32'(m_axis_tdata[2:1]));
					report_field("bridge_b_mode", 32'(want.bridge_b_mode),
						32'(m_axis_tdata[4:3]));
					report_field("steps_remaining", want.steps_remaining,
						m_axis_tdata[36:5]);
					report_field("move_done", 32'(want.move_done),
						32'(m_axis_tdata[37]));
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_drive.push_back(predict_sequencer(s_axis_tuser, s_axis_tdata));
		end
	end

	// Receiver: random stall bursts, plus one long hold-off on request.
	initial begin
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end else if (receiver_stalls_on && $urandom_range(0, 9) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Offers one item and waits for its transfer, then maybe idles for a burst.
	task automatic send_item(input logic cmd, input logic [31:0] count);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= count;
		do @(posedge clk); while (!s_axis_tready);
		if (sender_gaps_on && $urandom_range(0, 9) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	// Stops input and waits until every expected result has been seen.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_drive.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes the registers while the block is idle; the period only when asked.
	task automatic configure_sequencer(input logic enable, input logic [1:0] dir,
			input logic [15:0] period, input bit write_period);
		drain_results();
		cfg_wen <= 1'b1;
		cfg_index <= shs_pkg::REG_ENABLE;
		cfg_wdata <= {15'd0, enable};
		@(posedge clk);
		cfg_index <= shs_pkg::REG_DIRECTION;
		cfg_wdata <= {14'd0, dir};
		@(posedge clk);
		if (write_period) begin
			cfg_index <= shs_pkg::REG_PERIOD;
			cfg_wdata <= period;
			@(posedge clk);
			model_period = period;
		end
		cfg_wen <= 1'b0;
		model_enable = enable;
		model_dir = dir;
	endtask

	// Under the reset period a short run of ticks raises no step event.
	task automatic test_default_period();
		configure_sequencer(1'b1, shs_pkg::DIR_CW, 16'd0, 1'b0);
		send_item(CMD_LOAD, 32'd3);
		repeat (DEFAULT_TICKS) send_item(CMD_TICK, $urandom);
	endtask

	// Loads of the extreme counts, and a brake once the count runs out.
	task automatic test_move_done_and_load();
		configure_sequencer(1'b1, shs_pkg::DIR_CW, 16'd0, 1'b1);
		send_item(CMD_LOAD, 32'd0);
		send_item(CMD_TICK, 32'd0);
		send_item(CMD_LOAD, 32'hFFFF_FFFF);
		repeat (3) send_item(CMD_TICK, 32'hFFFF_FFFF);
	endtask

	// Direction reversals in both senses, and wrapping of the phase.
	task automatic test_reversal();
		configure_sequencer(1'b1, shs_pkg::DIR_CCW, 16'd0, 1'b1);
		repeat (3) send_item(CMD_TICK, 32'd0);
		configure_sequencer(1'b1, shs_pkg::DIR_CW, 16'd0, 1'b1);
		repeat (2) send_item(CMD_TICK, 32'd0);
	endtask

	// Stop, brake and disabled settings leave the outputs and the phase alone.
	task automatic test_inactive_modes();
		configure_sequencer(1'b1, shs_pkg::DIR_STOP, 16'd0, 1'b1);
		repeat (2) send_item(CMD_TICK, 32'd0);
		configure_sequencer(1'b1, shs_pkg::DIR_BRAKE, 16'd0, 1'b1);
		send_item(CMD_TICK, 32'd0);
		configure_sequencer(1'b0, shs_pkg::DIR_CW, 16'd0, 1'b1);
		repeat (2) send_item(CMD_TICK, 32'd0);
	endtask

	// Lowering the period below the running count fires on the next tick.
	task automatic test_period_lowered();
		configure_sequencer(1'b1, shs_pkg::DIR_CW, 16'hFFFF, 1'b1);
		repeat (4) send_item(CMD_TICK, 32'd0);
		configure_sequencer(1'b1, shs_pkg::DIR_CW, 16'd1, 1'b1);
		repeat (2) send_item(CMD_TICK, 32'd0);
		send_item(CMD_LOAD, $urandom);
	endtask

	// A long receiver hold-off while the sender keeps offering ticks.
	task automatic test_backpressure();
		configure_sequencer(1'b1, shs_pkg::DIR_CCW, 16'd2, 1'b1);
		send_item(CMD_LOAD, 32'd1000);
		sender_gaps_on = 1'b0;
		hold_request = 1'b1;
		repeat (60) send_item(CMD_TICK, 32'd0);
		sender_gaps_on = 1'b1;
	endtask

	// Random settings per phase, each phase a move: a load and then mostly ticks.
	task automatic test_random_moves();
		logic        enable;
		logic [1:0]  dir;
		logic [15:0] period;
		int          pick;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			// The closing phases run without idling on either side.
			if (phase >= RANDOM_PHASES - 2) begin
				sender_gaps_on = 1'b0;
				receiver_stalls_on = 1'b0;
			end
			enable = ($urandom_range(0, 9) != 0);
			if ($urandom_range(0, 9) < 8)
				dir = $urandom_range(0, 1) ? shs_pkg::DIR_CW : shs_pkg::DIR_CCW;
			else
				dir = $urandom_range(0, 1) ? shs_pkg::DIR_BRAKE : shs_pkg::DIR_STOP;
			pick = $urandom_range(0, 9);
			if (pick < 6)
				period = 16'($urandom_range(0, 7));
			else if (pick < 9)
				period = 16'($urandom_range(8, 40));
			else
				period = 16'($urandom_range(0, 65535));
			configure_sequencer(enable, dir, period, 1'b1);
			send_item(CMD_LOAD, $urandom_range(0, 30));
			for (int n = 1; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 19) == 0)
					send_item(CMD_LOAD, ($urandom_range(0, 3) == 0) ? $urandom
						: $urandom_range(0, 20));
				else
					send_item(CMD_TICK, $urandom);
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_wen <= 1'b0;
		cfg_index <= shs_pkg::REG_ENABLE;
		cfg_wdata <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= CMD_TICK;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_period();
		test_move_done_and_load();
		test_reversal();
		test_inactive_modes();
		test_period_lowered();
		test_backpressure();
		test_random_moves();

		drain_results();
		if (expected_drive.size() != 0) begin
			$display("%0t: results missing: expected %0d more, actual 0", $time,
				expected_drive.size());
			mismatch_count++;
		end
		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
